// ===== hw/rtl/ircu_pkg.sv =====
package ircu_pkg;

	localparam int NUM_INDEX = 4;
	localparam int INDEX_W = 32;
	localparam int RANGE_W = 10;
	localparam int OUT_CNT_W = 16;

	localparam logic [2:0] OP_NONE   = 3'd0;
	localparam logic [2:0] OP_ADD    = 3'd1;
	localparam logic [2:0] OP_MOVE   = 3'd2;
	localparam logic [2:0] OP_RANGE  = 3'd3;
	localparam logic [2:0] OP_MODULO = 3'd4;
	localparam logic [2:0] OP_LOAD0  = 3'd5;
	localparam logic [2:0] OP_LOAD1  = 3'd6;

	typedef struct packed {
		logic [2:0]         opcode;
		logic [1:0]         dest_index;
		logic [1:0]         src_index;
		logic [INDEX_W-1:0] operand_value;
		logic               dec_counter0;
		logic               dec_counter1;
	} item_t;

	typedef struct packed {
		logic ge;
		logic mi;
		logic z0;
		logic z1;
	} flags_t;

	typedef logic [NUM_INDEX-1:0][INDEX_W-1:0] index_file_t;
	typedef logic [NUM_INDEX-1:0][RANGE_W-1:0] range_file_t;

endpackage

// ===== hw/rtl/ircu_exec.sv =====
module ircu_exec #(
	parameter int COUNTER_WIDTH = 16
) (
	input  ircu_pkg::item_t       item,
	input  ircu_pkg::index_file_t idx_cur,
	input  ircu_pkg::range_file_t ranges,
	input  logic [COUNTER_WIDTH-1:0] cnt0_cur,
	input  logic [COUNTER_WIDTH-1:0] cnt1_cur,
	input  ircu_pkg::flags_t      flags_cur,
	output ircu_pkg::index_file_t idx_nxt,
	output logic [COUNTER_WIDTH-1:0] cnt0_nxt,
	output logic [COUNTER_WIDTH-1:0] cnt1_nxt,
	output ircu_pkg::flags_t      flags_nxt
);
	import ircu_pkg::*;

	logic [INDEX_W-1:0]       src_val;
	logic [15:0]              range_hi;
	logic                     neg;
	logic                     ge;
	logic [15:0]              wrap_hi;
	logic [COUNTER_WIDTH-1:0] cnt0_mid;
	logic [COUNTER_WIDTH-1:0] cnt1_mid;
	logic                     chk;

	assign src_val  = idx_cur[item.src_index];
	assign range_hi = 16'(ranges[item.src_index]);
	assign neg      = src_val[INDEX_W-1];
	assign ge       = !neg && (src_val[31:16] >= range_hi);
	assign chk      = (item.opcode == OP_RANGE) || (item.opcode == OP_MODULO);

	always_comb begin
		if (ge) begin
			wrap_hi = src_val[31:16] - range_hi;
		end else if (neg) begin
			wrap_hi = src_val[31:16] + range_hi;
		end else begin
			wrap_hi = src_val[31:16];
		end
	end

	always_comb begin
		idx_nxt  = idx_cur;
		cnt0_mid = cnt0_cur;
		cnt1_mid = cnt1_cur;
		unique case (item.opcode)
			OP_ADD: idx_nxt[item.dest_index] = idx_cur[item.dest_index] + item.operand_value;
			OP_MOVE: idx_nxt[item.dest_index] = item.operand_value;
			OP_MODULO: idx_nxt[item.dest_index] = {wrap_hi, idx_cur[item.dest_index][15:0]};
			OP_LOAD0: cnt0_mid = item.operand_value[COUNTER_WIDTH-1:0];
			OP_LOAD1: cnt1_mid = item.operand_value[COUNTER_WIDTH-1:0];
			default: ;
		endcase
	end

	always_comb begin
		flags_nxt = flags_cur;
		if (chk) begin
			flags_nxt.ge = ge;
			flags_nxt.mi = !ge && neg;
		end
		cnt0_nxt = cnt0_mid;
		cnt1_nxt = cnt1_mid;
		// a decrement saturates at zero and sets the zero flag when the result is zero
		if (item.dec_counter0) begin
			if (cnt0_mid != '0) begin
				cnt0_nxt = cnt0_mid - COUNTER_WIDTH'(1);
			end
			flags_nxt.z0 = (cnt0_mid <= COUNTER_WIDTH'(1));
		end
		if (item.dec_counter1) begin
			if (cnt1_mid != '0) begin
				cnt1_nxt = cnt1_mid - COUNTER_WIDTH'(1);
			end
			flags_nxt.z1 = (cnt1_mid <= COUNTER_WIDTH'(1));
		end
	end

endmodule

// ===== hw/rtl/index_register_control_unit.sv =====
// Index register control unit: four 16.16 index registers, two down counters
// and four condition flags. One transaction is accepted per clock unless the
// output stalls; each passes through an input register, then a result register,
// and items follow back to back. Only a stall on the output side holds the
// input side. Range registers are written through the cfg port, always ready;
// the user must do so with no transaction in flight: the block does not check.
module index_register_control_unit #(
	parameter int COUNTER_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [1:0]  dest_index,
	input  logic [1:0]  src_index,
	input  logic [31:0] operand_value,
	input  logic        dec_counter0,
	input  logic        dec_counter1,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] index_value,
	output logic        mod_ge_flag,
	output logic        mod_mi_flag,
	output logic        counter0_zero_flag,
	output logic        counter1_zero_flag,
	output logic [15:0] counter0_value,
	output logic [15:0] counter1_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data
);
	import ircu_pkg::*;

	logic                     valid_s1;
	item_t                    item_s1;
	logic                     advance;
	logic                     accept;

	index_file_t              idx_q;
	index_file_t              idx_nxt;
	range_file_t              range_q;
	logic [COUNTER_WIDTH-1:0] cnt0_q;
	logic [COUNTER_WIDTH-1:0] cnt1_q;
	logic [COUNTER_WIDTH-1:0] cnt0_nxt;
	logic [COUNTER_WIDTH-1:0] cnt1_nxt;
	flags_t                   flags_q;
	flags_t                   flags_nxt;

	logic                     valid_s2;
	logic [INDEX_W-1:0]       index_s2;
	logic [31:0]              cnt0_ext;
	logic [31:0]              cnt1_ext;

	assign advance   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{opcode: opcode, dest_index: dest_index, src_index: src_index,
				operand_value: operand_value, dec_counter0: dec_counter0,
				dec_counter1: dec_counter1};
		end
	end

	ircu_exec #(
		.COUNTER_WIDTH(COUNTER_WIDTH)
	) u_exec (
		.item      (item_s1),
		.idx_cur   (idx_q),
		.ranges    (range_q),
		.cnt0_cur  (cnt0_q),
		.cnt1_cur  (cnt1_q),
		.flags_cur (flags_q),
		.idx_nxt   (idx_nxt),
		.cnt0_nxt  (cnt0_nxt),
		.cnt1_nxt  (cnt1_nxt),
		.flags_nxt (flags_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			range_q  <= '0;
			cnt0_q   <= '0;
			cnt1_q   <= '0;
			flags_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				range_q[cfg_index] <= cfg_data;
			end
			if (advance) begin
				idx_q    <= idx_nxt;
				cnt0_q   <= cnt0_nxt;
				cnt1_q   <= cnt1_nxt;
				flags_q  <= flags_nxt;
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			index_s2 <= idx_nxt[item_s1.dest_index];
		end
	end

	// flags and counters are the live state, frozen while a result is pending
	assign cnt0_ext           = 32'(cnt0_q);
	assign cnt1_ext           = 32'(cnt1_q);
	assign out_valid          = valid_s2;
	assign index_value        = index_s2;
	assign mod_ge_flag        = flags_q.ge;
	assign mod_mi_flag        = flags_q.mi;
	assign counter0_zero_flag = flags_q.z0;
	assign counter1_zero_flag = flags_q.z1;
	assign counter0_value     = cnt0_ext[OUT_CNT_W-1:0];
	assign counter1_value     = cnt1_ext[OUT_CNT_W-1:0];

endmodule

// ===== test/index_register_control_unit_tb.sv =====
module index_register_control_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ircu_pkg::*;

	localparam logic [2:0] OP_SPARE = 3'd7;

	localparam logic [1:0] REG_X_RANGE = 2'd0;
	localparam logic [1:0] REG_Y_RANGE = 2'd1;
	localparam logic [1:0] REG_U_RANGE = 2'd2;
	localparam logic [1:0] REG_V_RANGE = 2'd3;

	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 275;
	localparam int HOLD_CYCLES = 80;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [INDEX_W-1:0]   index_value;
		flags_t               flags;
		logic [OUT_CNT_W-1:0] count0;
		logic [OUT_CNT_W-1:0] count1;
	} unit_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	item_t       drive_item = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] index_value;
	logic        mod_ge_flag;
	logic        mod_mi_flag;
	logic        counter0_zero_flag;
	logic        counter1_zero_flag;
	logic [15:0] counter0_value;
	logic [15:0] counter1_value;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [9:0]  cfg_data = '0;

	// index unit model state
	logic [INDEX_W-1:0]   idx_model [NUM_INDEX] = '{default: '0};
	logic [RANGE_W-1:0]   range_model [NUM_INDEX] = '{default: '0};
	logic [OUT_CNT_W-1:0] count0_model = '0;
	logic [OUT_CNT_W-1:0] count1_model = '0;
	flags_t               flags_model = '0;

	logic [RANGE_W-1:0] phase_ranges [NUM_INDEX] = '{default: '0};

	item_t        pending_items [$];
	unit_result_t expected_results [$];
	unit_result_t want;
	unit_result_t got;

	bit          item_taken = 1'b0;
	bit          hold_trigger = 1'b0;
	int unsigned hold_left = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned items_queued = 0;
	int unsigned results_done = 0;
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;

	index_register_control_unit i_dut (
		.clk,
		.arst_n,
		.in_valid,
		.in_stall,
		.opcode        (drive_item.opcode),
		.dest_index    (drive_item.dest_index),
		.src_index     (drive_item.src_index),
		.operand_value (drive_item.operand_value),
		.dec_counter0  (drive_item.dec_counter0),
		.dec_counter1  (drive_item.dec_counter1),
		.out_valid,
		.out_stall,
		.index_value,
		.mod_ge_flag,
		.mod_mi_flag,
		.counter0_zero_flag,
		.counter1_zero_flag,
		.counter0_value,
		.counter1_value,
		.cfg_valid,
		.cfg_ready,
		.cfg_index,
		.cfg_data
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic unit_result_t apply_item(item_t it);
		logic [INDEX_W-1:0] span;
		logic [INDEX_W-1:0] cur;
		logic [INDEX_W-1:0] wrapped;
		unit_result_t res;
		span = {6'b0, range_model[it.src_index], 16'b0};
		cur = idx_model[it.src_index];
		case (it.opcode)
			OP_ADD: idx_model[it.dest_index] = idx_model[it.dest_index] + it.operand_value;
			OP_MOVE: idx_model[it.dest_index] = it.operand_value;
			OP_RANGE, OP_MODULO: begin
				flags_model.ge = !cur[31] && (cur[31:16] >= span[31:16]);
				flags_model.mi = !flags_model.ge && cur[31];
				wrapped = flags_model.ge ? cur - span : (flags_model.mi ? cur + span : cur);
				if (it.opcode == OP_MODULO) begin
					idx_model[it.dest_index][31:16] = wrapped[31:16];
				end
			end
			OP_LOAD0: count0_model = it.operand_value[OUT_CNT_W-1:0];
			OP_LOAD1: count1_model = it.operand_value[OUT_CNT_W-1:0];
			default: ;
		endcase
		// zero flag ends up set when the counter was 0 or 1 before the step
		if (it.dec_counter0) begin
			flags_model.z0 = (count0_model <= 1);
			if (count0_model != 0) count0_model = count0_model - 1'b1;
		end
		if (it.dec_counter1) begin
			flags_model.z1 = (count1_model <= 1);
			if (count1_model != 0) count1_model = count1_model - 1'b1;
		end
		res.index_value = idx_model[it.dest_index];
		res.flags = flags_model;
		res.count0 = count0_model;
		res.count1 = count1_model;
		return res;
	endfunction

	task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
		if (want_v !== got_v) begin
			$error("%s: expected %h, actual %h", name, want_v, got_v);
			fail_count++;
		end
	endtask

	// sender
	always @(negedge clk) begin
		if (arst_n && (!in_valid || item_taken)) begin
			item_taken = 1'b0;
			if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				drive_item <= pending_items.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver, with one long hold-off on request
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_trigger) begin
			hold_trigger = 1'b0;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// monitor: results first, then newly accepted transactions
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result transaction with no expectation pending");
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					got = {index_value, mod_ge_flag, mod_mi_flag, counter0_zero_flag,
						counter1_zero_flag, counter0_value, counter1_value};
					check_field("index_value", want.index_value, got.index_value);
					check_field("mod_ge_flag", 32'(want.flags.ge), 32'(got.flags.ge));
					check_field("mod_mi_flag", 32'(want.flags.mi), 32'(got.flags.mi));
					check_field("counter0_zero_flag", 32'(want.flags.z0),
						32'(got.flags.z0));
					check_field("counter1_zero_flag", 32'(want.flags.z1),
						32'(got.flags.z1));
					check_field("counter0_value", 32'(want.count0), 32'(got.count0));
					check_field("counter1_value", 32'(want.count1), 32'(got.count1));
					results_done++;
				end
			end
			if (in_valid && !in_stall) begin
				expected_results.push_back(apply_item(drive_item));
				item_taken = 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				range_model[cfg_index] = cfg_data;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic write_range(logic [1:0] reg_idx, logic [9:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= reg_idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_ranges(logic [9:0] x, logic [9:0] y, logic [9:0] u, logic [9:0] v);
		write_range(REG_X_RANGE, x);
		write_range(REG_Y_RANGE, y);
		write_range(REG_U_RANGE, u);
		write_range(REG_V_RANGE, v);
		phase_ranges[REG_X_RANGE] = x;
		phase_ranges[REG_Y_RANGE] = y;
		phase_ranges[REG_U_RANGE] = u;
		phase_ranges[REG_V_RANGE] = v;
	endtask

	task automatic add_op(logic [2:0] op, logic [1:0] dst, logic [1:0] src, logic [31:0] val,
		logic dec0, logic dec1);
		item_t it;
		it.opcode = op;
		it.dest_index = dst;
		it.src_index = src;
		it.operand_value = val;
		it.dec_counter0 = dec0;
		it.dec_counter1 = dec1;
		pending_items.push_back(it);
		items_queued++;
	endtask

	// index values, half of them clustered around the range limit or around zero
	function automatic logic [31:0] near_bound(logic [1:0] sel);
		logic [15:0] whole;
		case ($urandom_range(0, 3))
			0: whole = 16'(phase_ranges[sel]) + 16'($urandom_range(0, 4)) - 16'd2;
			1: whole = 16'($urandom_range(0, 4)) - 16'd2;
			2: whole = 16'($urandom_range(0, 1100));
			default: whole = 16'($urandom);
		endcase
		return {whole, 16'($urandom)};
	endfunction

	task automatic queue_random(int unsigned count);
		logic [2:0]  op;
		logic [1:0]  dst;
		logic [31:0] val;
		int          pick;
		int          step;
		repeat (count) begin
			dst = 2'($urandom_range(0, 3));
			val = $urandom;
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				op = $urandom_range(0, 1) ? OP_MODULO : OP_RANGE;
			end else if (pick < 50) begin
				op = OP_MOVE;
				val = near_bound(dst);
			end else if (pick < 65) begin
				op = OP_ADD;
				step = $urandom_range(0, 8) - 4;
				if ($urandom_range(0, 1)) val = {16'(step), 16'($urandom)};
			end else if (pick < 80) begin
				op = $urandom_range(0, 1) ? OP_LOAD0 : OP_LOAD1;
				if ($urandom_range(0, 3) != 0) val = $urandom_range(0, 6);
			end else if (pick < 95) begin
				op = OP_NONE;
			end else begin
				op = OP_SPARE;
			end
			add_op(op, dst, 2'($urandom_range(0, 3)), val,
				$urandom_range(0, 2) == 0, $urandom_range(0, 2) == 0);
		end
	endtask

	task automatic queue_directed();
		add_op(OP_LOAD0, 2'd0, 2'd0, 32'hFFFF_FFFF, 1'b1, 1'b0);
		add_op(OP_LOAD1, 2'd0, 2'd0, 32'h0000_0001, 1'b0, 1'b1);
		// decrement of a counter already at zero
		add_op(OP_NONE, 2'd0, 2'd0, 32'h0, 1'b0, 1'b1);
		add_op(OP_LOAD1, 2'd0, 2'd0, 32'hABCD_0002, 1'b1, 1'b1);
		add_op(OP_LOAD0, 2'd0, 2'd0, 32'h0001_0000, 1'b1, 1'b0);
		add_op(OP_SPARE, 2'd1, 2'd2, 32'hFFFF_FFFF, 1'b1, 1'b1);
		add_op(OP_MOVE, 2'd0, 2'd0, 32'h7FFF_FFFF, 1'b0, 1'b0);
		add_op(OP_RANGE, 2'd1, 2'd0, 32'h0, 1'b0, 1'b0);
		add_op(OP_MODULO, 2'd0, 2'd0, 32'h0, 1'b0, 1'b0);
		add_op(OP_MOVE, 2'd1, 2'd0, 32'h8000_0000, 1'b0, 1'b0);
		add_op(OP_RANGE, 2'd2, 2'd1, 32'h0, 1'b0, 1'b0);
		add_op(OP_MODULO, 2'd1, 2'd1, 32'h0, 1'b0, 1'b0);
		// integer part exactly at the limit
		add_op(OP_MOVE, 2'd2, 2'd0, 32'h0005_FFFF, 1'b0, 1'b0);
		add_op(OP_RANGE, 2'd0, 2'd2, 32'h0, 1'b0, 1'b0);
		add_op(OP_MODULO, 2'd3, 2'd2, 32'h0, 1'b0, 1'b0);
		add_op(OP_MOVE, 2'd2, 2'd0, 32'h0004_FFFF, 1'b0, 1'b0);
		add_op(OP_RANGE, 2'd0, 2'd2, 32'h0, 1'b0, 1'b0);
		add_op(OP_MOVE, 2'd3, 2'd0, 32'hFFFF_8000, 1'b0, 1'b0);
		add_op(OP_MODULO, 2'd3, 2'd3, 32'h0, 1'b0, 1'b0);
		add_op(OP_ADD, 2'd0, 2'd0, 32'hFFFF_FFFF, 1'b0, 1'b0);
		add_op(OP_ADD, 2'd0, 2'd0, 32'h0001_0000, 1'b0, 1'b0);
		add_op(OP_MOVE, 2'd2, 2'd0, 32'h0, 1'b0, 1'b0);
		add_op(OP_ADD, 2'd2, 2'd0, 32'h0, 1'b0, 1'b0);
		add_op(OP_MODULO, 2'd0, 2'd1, 32'h0, 1'b0, 1'b0);
	endtask

	task automatic drain();
		do @(negedge clk); while (results_done != items_queued);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);
		for (int p = 0; p < PHASES; p++) begin
			case (p / 2)
				0: begin
					send_idle_pct = 28;
					recv_idle_pct = 57;
				end
				1: begin
					send_idle_pct = 57;
					recv_idle_pct = 28;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			case (p)
				0: set_ranges(10'd1023, 10'd0, 10'd5, 10'd512);
				1: set_ranges(10'd0, 10'd0, 10'd0, 10'd0);
				2: set_ranges(10'd1023, 10'd1023, 10'd1023, 10'd1023);
				default: set_ranges(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
					10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
			endcase
			if (p == 0) queue_directed();
			queue_random(PHASE_ITEMS);
			if (p == 4) hold_trigger = 1'b1;
			drain();
		end
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== index_register_control_unit.f =====
hw/rtl/ircu_pkg.sv
hw/rtl/ircu_exec.sv
hw/rtl/index_register_control_unit.sv
test/index_register_control_unit_tb.sv
